### src/sorted_key_table_defines.svh
// ----------------------------------------------------------------------------
// sorted_key_table_defines.svh
// Assertion macros shared by the sorted key table RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SKT_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define SKT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Sizes, codes and types shared by the sorted key table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  localparam int DEPTH         = 64;
  localparam int PAYLOAD_WIDTH = 16;
  localparam int KEY_WIDTH     = 32;
  localparam int AW            = $clog2(DEPTH);
  localparam int CW            = $clog2(DEPTH + 1);

  // Request codes.
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_RESOLVE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_FINISH
  } skt_state_t;

  // Access to the entry store: one write and one read per cycle.
  typedef struct packed {
    logic                     we;
    logic [AW-1:0]            waddr;
    logic [KEY_WIDTH-1:0]     wkey;
    logic [PAYLOAD_WIDTH-1:0] wpay;
    logic [AW-1:0]            raddr;
  } skt_mem_req_t;

endpackage

`default_nettype wire

### src/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Sorted table of up to DEPTH key/payload entries with binary search lookup,
// ordered insert and remove.
//
// Each request (lookup, insert or remove) is taken when the block is idle and
// answered with exactly one result. The entries live in a single-port-read
// memory, so each binary search probe has an address step and then a compare
// step on the registered read data, and an insert or remove that changes the
// table moves the later entries one at a time, with a read step and a write
// step per entry, and then commits. Equal keys may coexist; a new entry goes
// after an equal key that the search lands on. An insert into a full table
// reports full and changes nothing. The result sits in an output register,
// so a new request may be accepted while the previous result still waits to
// be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_key_table_defines.svh"

module sorted_key_table
  import skt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,

  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_req_type,
  input  wire logic [KEY_WIDTH-1:0]     in_key,
  input  wire logic [PAYLOAD_WIDTH-1:0] in_payload_in,

  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    out_status,
  output logic [PAYLOAD_WIDTH-1:0]      out_payload_out,
  output logic [5:0]                    out_position,
  output logic [6:0]                    out_entry_count
);

  // Sequencer state.
  skt_state_t state_r, state_nxt;

  // Latched request.
  logic [1:0]               req_r, req_nxt;
  logic [KEY_WIDTH-1:0]     key_r, key_nxt;
  logic [PAYLOAD_WIDTH-1:0] pay_r, pay_nxt;

  // Number of entries held.
  logic [CW-1:0]            count_r, count_nxt;

  // Search window [lo, hi) and the last midpoint probed.
  logic [CW-1:0]            lo_r, lo_nxt;
  logic [CW-1:0]            hi_r, hi_nxt;
  logic [AW-1:0]            mid_r, mid_nxt;
  logic                     le_r, le_nxt;
  logic                     found_r, found_nxt;

  // Shift walker: source index and entries still to move.
  logic [AW-1:0]            src_r, src_nxt;
  logic [CW-1:0]            rem_r, rem_nxt;

  // Result being built.
  logic [1:0]               res_status_r, res_status_nxt;
  logic [PAYLOAD_WIDTH-1:0] res_pay_r, res_pay_nxt;
  logic [AW-1:0]            res_pos_r, res_pos_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r, out_status_nxt;
  logic [PAYLOAD_WIDTH-1:0] out_pay_r, out_pay_nxt;
  logic [AW-1:0]            out_pos_r, out_pos_nxt;
  logic [CW-1:0]            out_cnt_r, out_cnt_nxt;

  // Memory access and read data.
  skt_mem_req_t             mem_req;
  logic [KEY_WIDTH-1:0]     rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;

  logic                     in_acc;
  logic                     out_free;
  logic [CW:0]              mid_sum;
  logic [AW-1:0]            mid_w;
  logic [AW-1:0]            ins_pos;

  skt_store u_store (
    .clk    (clk),
    .req    (mem_req),
    .rd_key (rd_key),
    .rd_pay (rd_pay)
  );

  // The block takes a request only from the idle state.
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Midpoint floor((lo + hi_incl) / 2) with hi_incl = hi - 1; only used when
  // lo < hi, so hi is at least one.
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - (CW+1)'(1);
  assign mid_w   = mid_sum[AW:1];

  // Insert position: just after the last probe when its key is not larger.
  assign ins_pos = le_r ? (mid_r + AW'(1)) : mid_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_INSERT) begin
            if (count_r == CW'(DEPTH)) begin
              state_nxt = S_FINISH;
            end else if (count_r == '0) begin
              state_nxt = S_PLACE;
            end else begin
              state_nxt = S_PROBE;
            end
          end else if ((in_req_type inside {REQ_LOOKUP, REQ_REMOVE}) &&
                       count_r != '0) begin
            state_nxt = S_PROBE;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_PROBE: begin
        state_nxt = (lo_r < hi_r) ? S_CMP : S_RESOLVE;
      end
      S_CMP: begin
        state_nxt = (rd_key == key_r) ? S_RESOLVE : S_PROBE;
      end
      S_RESOLVE: begin
        case (req_r)
          REQ_INSERT: begin
            state_nxt = (count_r != CW'(ins_pos)) ? S_SHIFT_RD : S_PLACE;
          end
          REQ_REMOVE: begin
            if (!found_r) begin
              state_nxt = S_FINISH;
            end else if (count_r - CW'(1) != CW'(mid_r)) begin
              state_nxt = S_SHIFT_RD;
            end else begin
              state_nxt = S_PLACE;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_SHIFT_RD: begin
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_nxt = (rem_r == CW'(1)) ? S_PLACE : S_SHIFT_RD;
      end
      S_PLACE: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    req_nxt        = req_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    le_nxt         = le_r;
    found_nxt      = found_r;
    src_nxt        = src_r;
    rem_nxt        = rem_r;
    res_status_nxt = res_status_r;
    res_pay_nxt    = res_pay_r;
    res_pos_nxt    = res_pos_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_pay_nxt    = out_pay_r;
    out_pos_nxt    = out_pos_r;
    out_cnt_nxt    = out_cnt_r;

    mem_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt        = in_req_type;
          key_nxt        = in_key;
          pay_nxt        = in_payload_in;
          lo_nxt         = '0;
          hi_nxt         = count_r;
          mid_nxt        = '0;
          le_nxt         = 1'b0;
          found_nxt      = 1'b0;
          res_pay_nxt    = '0;
          res_pos_nxt    = '0;
          res_status_nxt = STAT_NOT_FOUND;
          if (in_req_type == REQ_INSERT) begin
            res_status_nxt = (count_r == CW'(DEPTH)) ? STAT_FULL : STAT_OK;
          end
        end
      end
      S_PROBE: begin
        if (lo_r < hi_r) begin
          mem_req.raddr = mid_w;
          mid_nxt       = mid_w;
        end
      end
      S_CMP: begin
        le_nxt = (rd_key <= key_r);
        if (rd_key == key_r) begin
          found_nxt = 1'b1;
          if (req_r == REQ_LOOKUP) begin
            res_status_nxt = STAT_OK;
            res_pay_nxt    = rd_pay;
            res_pos_nxt    = mid_r;
          end
        end else if (rd_key < key_r) begin
          lo_nxt = CW'(mid_r) + CW'(1);
        end else begin
          hi_nxt = CW'(mid_r);
        end
      end
      S_RESOLVE: begin
        case (req_r)
          REQ_INSERT: begin
            res_pos_nxt = ins_pos;
            rem_nxt     = count_r - CW'(ins_pos);
            src_nxt     = AW'(count_r - CW'(1));
          end
          REQ_REMOVE: begin
            if (found_r) begin
              res_status_nxt = STAT_OK;
              res_pos_nxt    = mid_r;
              rem_nxt        = count_r - CW'(1) - CW'(mid_r);
              src_nxt        = mid_r + AW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT_RD: begin
        mem_req.raddr = src_r;
      end
      S_SHIFT_WR: begin
        mem_req.we   = 1'b1;
        mem_req.wkey = rd_key;
        mem_req.wpay = rd_pay;
        rem_nxt      = rem_r - CW'(1);
        if (req_r == REQ_INSERT) begin
          mem_req.waddr = src_r + AW'(1);
          src_nxt       = src_r - AW'(1);
        end else begin
          mem_req.waddr = src_r - AW'(1);
          src_nxt       = src_r + AW'(1);
        end
      end
      S_PLACE: begin
        if (req_r == REQ_INSERT) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = res_pos_r;
          mem_req.wkey  = key_r;
          mem_req.wpay  = pay_r;
          count_nxt     = count_r + CW'(1);
        end else begin
          count_nxt     = count_r - CW'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pay_nxt    = res_pay_r;
          out_pos_nxt    = res_pos_r;
          out_cnt_nxt    = count_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    le_r         <= le_nxt;
    found_r      <= found_nxt;
    src_r        <= src_nxt;
    rem_r        <= rem_nxt;
    res_status_r <= res_status_nxt;
    res_pay_r    <= res_pay_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pay_r    <= out_pay_nxt;
    out_pos_r    <= out_pos_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_payload_out = out_pay_r;
  assign out_position    = 6'(out_pos_r);
  assign out_entry_count = 7'(out_cnt_r);

  // The table never holds more entries than it has room for.
  `SKT_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH), "entry count beyond depth")

  // An accepted request always starts work, so the next cycle is busy.
  `SKT_ASSERT_NEXT(a_accept_busy, in_acc, state_r != S_IDLE, "request accepted but idle")

  // A full report is only given when the table is in fact full.
  `SKT_ASSERT_IMPL(a_full_count, out_valid_r && out_status_r == STAT_FULL, out_cnt_r == CW'(DEPTH), "full reported below depth")

  // The entry count only moves in the commit step.
  `SKT_ASSERT_NEXT(a_count_commit, state_r != S_PLACE, $stable(count_r), "count changed outside commit")

endmodule

`default_nettype wire

### src/skt_store.sv
// ----------------------------------------------------------------------------
// skt_store
// Key and payload memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skt_store
  import skt_pkg::*;
(
  input  wire logic                     clk,
  input  wire skt_mem_req_t             req,
  output logic [KEY_WIDTH-1:0]          rd_key,
  output logic [PAYLOAD_WIDTH-1:0]      rd_pay
);

  logic [KEY_WIDTH-1:0]     key_mem [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      key_mem[req.waddr] <= req.wkey;
      pay_mem[req.waddr] <= req.wpay;
    end
  end

  always_ff @(posedge clk) begin
    rd_key <= key_mem[req.raddr];
    rd_pay <= pay_mem[req.raddr];
  end

endmodule

`default_nettype wire

### tb/sorted_key_table_test.sv
// ----------------------------------------------------------------------------
// sorted_key_table_test
// Self-checking bench for the sorted key table. A short table of directed
// requests covers the empty table, extreme keys and payloads, equal keys, the
// unused request code and misses. Then random episodes grow, fill, churn and
// drain the table. Every result is checked field by field against a shadow
// copy of the table updated as each request is taken, or a fixed row's result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_table_test;
  import skt_pkg::*;

  // The request code that the block must answer as not found and otherwise
  // ignore.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1850;
  localparam int N_DIRECTED   = 23;
  // An insert near the front of a nearly full table is the slowest request:
  // a full search plus a read and a write for each entry that moves.
  localparam int TAIL_CYCLES  = 200;
  localparam int LIMIT_NS     = 20_000_000;

  // One result as the block reports it.
  typedef struct packed {
    logic [1:0]               status;
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic [5:0]               position;
    logic [6:0]               count;
  } table_result_t;

  // One row of the directed table. When fixed is set, the row carries its
  // own expected result; otherwise the shadow table predicts it.
  typedef struct {
    logic [1:0]               req;
    logic [KEY_WIDTH-1:0]     key;
    logic [PAYLOAD_WIDTH-1:0] pay;
    bit                       fixed;
    table_result_t            want;
  } directed_row_t;

  typedef enum {EP_GROW, EP_FILL, EP_DRAIN, EP_CHURN, EP_MIXED} episode_t;

  localparam table_result_t NO_WANT = '0;

  logic                     clk   = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_req_type   = REQ_LOOKUP;
  logic [KEY_WIDTH-1:0]     in_key        = '0;
  logic [PAYLOAD_WIDTH-1:0] in_payload_in = '0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic [1:0]               out_status;
  logic [PAYLOAD_WIDTH-1:0] out_payload_out;
  logic [5:0]               out_position;
  logic [6:0]               out_entry_count;

  sorted_key_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_key          (in_key),
    .in_payload_in   (in_payload_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_payload_out (out_payload_out),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

  always #6 clk = ~clk;

  // Shadow copy of the table. Only entries below shadow_held are ever read,
  // and all of those have been written by an insert.
  logic [KEY_WIDTH-1:0]     shadow_keys [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] shadow_pays [DEPTH];
  int                       shadow_held = 0;

  // Results predicted for requests taken but not yet answered, oldest first.
  table_result_t            awaited_results [$];

  directed_row_t            directed_rows [N_DIRECTED];

  // Quiet stretches: one or both sides stop idling for a whole episode.
  bit tx_no_gap   = 1'b0;
  bit rx_no_stall = 1'b0;

  int mismatch_count = 0;
  int requests_taken = 0;
  int requests_live  = 0;  // requests with a real code
  int results_seen   = 0;
  int lookup_hits    = 0;
  int misses         = 0;
  int inserts_done   = 0;
  int removes_done   = 0;
  int full_refusals  = 0;
  int ignored_codes  = 0;
  int peak_held      = 0;

  // Binary search over the shadow table, midpoint rounded down. Returns 1 on
  // the first midpoint that matches; last_mid is the final midpoint probed.
  function automatic bit search_shadow(input logic [KEY_WIDTH-1:0] key,
                                       output int last_mid);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_held - 1;
    mid = 0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_keys[mid] < key) begin
        lo = mid + 1;
      end else if (shadow_keys[mid] > key) begin
        hi = mid - 1;
      end else begin
        last_mid = mid;
        return 1'b1;
      end
    end
    last_mid = mid;
    return 1'b0;
  endfunction

  // Applies one request to the shadow table and returns the result that the
  // block must give for it.
  function automatic table_result_t apply_request(input logic [1:0] req,
                                                  input logic [KEY_WIDTH-1:0] key,
                                                  input logic [PAYLOAD_WIDTH-1:0] pay);
    table_result_t r;
    int            m;
    int            p;
    bit            hit;
    r = '{STAT_NOT_FOUND, '0, '0, '0};
    m = 0;
    case (req)
      REQ_LOOKUP: begin
        hit = search_shadow(key, m);
        if (hit) begin
          r.status   = STAT_OK;
          r.payload  = shadow_pays[m];
          r.position = m[5:0];
          lookup_hits++;
        end else begin
          misses++;
        end
      end
      REQ_INSERT: begin
        if (shadow_held >= DEPTH) begin
          r.status = STAT_FULL;
          full_refusals++;
        end else begin
          p = 0;
          if (shadow_held != 0) begin
            hit = search_shadow(key, m);
            // A new key lands after an equal or smaller key at the last probe.
            p = (shadow_keys[m] <= key) ? m + 1 : m;
          end
          for (int i = shadow_held - 1; i >= p; i--) begin
            shadow_keys[i + 1] = shadow_keys[i];
            shadow_pays[i + 1] = shadow_pays[i];
          end
          shadow_keys[p] = key;
          shadow_pays[p] = pay;
          shadow_held++;
          r.status   = STAT_OK;
          r.position = p[5:0];
          inserts_done++;
          if (shadow_held > peak_held) peak_held = shadow_held;
        end
      end
      REQ_REMOVE: begin
        hit = search_shadow(key, m);
        if (hit) begin
          for (int i = m; i < shadow_held - 1; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_pays[i] = shadow_pays[i + 1];
          end
          shadow_held--;
          r.status   = STAT_OK;
          r.position = m[5:0];
          removes_done++;
        end else begin
          misses++;
        end
      end
      default: begin
        ignored_codes++;
      end
    endcase
    r.count = shadow_held[6:0];
    return r;
  endfunction

  // Presents one request, holds it until the block takes it, then records
  // the result that must come back for it.
  task automatic issue_request(input logic [1:0] req,
                               input logic [KEY_WIDTH-1:0] key,
                               input logic [PAYLOAD_WIDTH-1:0] pay,
                               input bit fixed,
                               input table_result_t want);
    int            gap;
    table_result_t predicted;
    gap = tx_no_gap ? 0 : $urandom_range(0, 16);
    // With no gap, valid stays high from the previous request, so it gets
    // only the one assignment below in this time step.
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_key        <= key;
    in_payload_in <= pay;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(req, key, pay);
    awaited_results.push_back(fixed ? want : predicted);
    requests_taken++;
    if (req != REQ_UNUSED) requests_live++;
  endtask

  // Stops sending and waits until every request has been answered.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Keys come from the table itself, from just beside a held key (a near
  // miss), from a small pool that makes equal keys common, from the extremes
  // of the key range, or from the whole range.
  function automatic logic [KEY_WIDTH-1:0] pick_key(input bit narrow);
    int                   sel;
    logic [KEY_WIDTH-1:0] k;
    sel = $urandom_range(0, 9);
    if (shadow_held > 0 && sel < 4) begin
      k = shadow_keys[$urandom_range(0, shadow_held - 1)];
      if (sel == 3) k = $urandom_range(0, 1) ? k + 32'd1 : k - 32'd1;
    end else if (narrow || sel < 6) begin
      k = $urandom_range(0, 15);
    end else if (sel == 6) begin
      case ($urandom_range(0, 3))
        0:       k = 32'h0000_0000;
        1:       k = 32'hFFFF_FFFF;
        2:       k = 32'h7FFF_FFFF;
        default: k = 32'h8000_0000;
      endcase
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  function automatic logic [1:0] pick_req(input episode_t mode);
    int r;
    r = $urandom_range(0, 19);
    if (r == 19) return REQ_UNUSED;
    case (mode)
      EP_GROW:  return (r < 14) ? REQ_INSERT : (r < 17) ? REQ_LOOKUP : REQ_REMOVE;
      EP_CHURN: return (r < 7) ? REQ_INSERT : (r < 13) ? REQ_REMOVE : REQ_LOOKUP;
      default:  return (r < 6) ? REQ_INSERT : (r < 12) ? REQ_REMOVE : REQ_LOOKUP;
    endcase
  endfunction

  function automatic logic [PAYLOAD_WIDTH-1:0] pick_payload();
    return PAYLOAD_WIDTH'($urandom);
  endfunction

  // One episode of random traffic. Each ends with the sender paused until
  // every result is back, so the next episode starts from a quiet block.
  task automatic run_episode(input episode_t mode);
    int len;
    tx_no_gap   = ($urandom_range(0, 3) == 0);
    rx_no_stall = ($urandom_range(0, 3) == 0);
    case (mode)
      EP_FILL: begin
        // Fill to the brim, then knock on the full table a few times.
        while (shadow_held < DEPTH)
          issue_request(REQ_INSERT, pick_key(1'b0), pick_payload(), 1'b0, NO_WANT);
        repeat (8)
          issue_request($urandom_range(0, 1) ? REQ_INSERT : REQ_LOOKUP,
                        pick_key(1'b0), pick_payload(), 1'b0, NO_WANT);
      end
      EP_DRAIN: begin
        // Removes of held keys always hit, so the table empties for sure.
        while (shadow_held > 0) begin
          if ($urandom_range(0, 9) < 8)
            issue_request(REQ_REMOVE, shadow_keys[$urandom_range(0, shadow_held - 1)],
                          pick_payload(), 1'b0, NO_WANT);
          else
            issue_request(REQ_LOOKUP, pick_key(1'b0), pick_payload(), 1'b0, NO_WANT);
        end
        repeat (3)
          issue_request($urandom_range(0, 1) ? REQ_REMOVE : REQ_LOOKUP,
                        pick_key(1'b0), pick_payload(), 1'b0, NO_WANT);
      end
      default: begin
        len = $urandom_range(40, 120);
        repeat (len)
          issue_request(pick_req(mode), pick_key(mode == EP_CHURN), pick_payload(),
                        1'b0, NO_WANT);
      end
    endcase
    wait_drained();
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: draws a stall for every result, then takes it and checks it
  // against the oldest prediction. Outputs are read right after the edge, so
  // they hold the values the block had at that edge.
  initial begin : result_side
    int            hold;
    table_result_t want;
    wait (rst_n);
    forever begin
      hold = rx_no_stall ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      results_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual status %0h",
                 $time, out_status);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("status",      want.status,   out_status);
        compare_field("payload_out", want.payload,  out_payload_out);
        compare_field("position",    want.position, out_position);
        compare_field("entry_count", want.count,    out_entry_count);
      end
    end
  end

  // Request side: reset, the directed table, random episodes, then the end.
  initial begin : request_side
    int       live_target;
    int       pick;
    episode_t mode;

    // Rows with a fixed result are the ones that follow from the empty
    // table, a miss or the unused code; all others go to the shadow table.
    directed_rows = '{
      // Empty table: lookup, remove and the unused code all miss.
      '{REQ_LOOKUP, 32'h0000_0000, 16'h0000, 1'b1, '{STAT_NOT_FOUND, 16'h0, 6'd0, 7'd0}},
      '{REQ_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{STAT_NOT_FOUND, 16'h0, 6'd0, 7'd0}},
      '{REQ_UNUSED, 32'hAAAA_AAAA, 16'h5555, 1'b1, '{STAT_NOT_FOUND, 16'h0, 6'd0, 7'd0}},
      // First insert into an empty table lands at position zero.
      '{REQ_INSERT, 32'h8000_0000, 16'hFFFF, 1'b1, '{STAT_OK, 16'h0, 6'd0, 7'd1}},
      '{REQ_INSERT, 32'h0000_0000, 16'h0000, 1'b0, NO_WANT},
      '{REQ_INSERT, 32'hFFFF_FFFF, 16'h5A5A, 1'b0, NO_WANT},
      // An equal key goes beside the one already held.
      '{REQ_INSERT, 32'h8000_0000, 16'h1234, 1'b0, NO_WANT},
      '{REQ_INSERT, 32'h7FFF_FFFF, 16'hA5A5, 1'b0, NO_WANT},
      '{REQ_LOOKUP, 32'h8000_0000, 16'h0000, 1'b0, NO_WANT},
      '{REQ_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, NO_WANT},
      '{REQ_LOOKUP, 32'h0000_0000, 16'h0000, 1'b0, NO_WANT},
      // Misses leave five entries in place.
      '{REQ_LOOKUP, 32'h7FFF_FFFE, 16'h0000, 1'b1, '{STAT_NOT_FOUND, 16'h0, 6'd0, 7'd5}},
      '{REQ_UNUSED, 32'h5555_5555, 16'hAAAA, 1'b1, '{STAT_NOT_FOUND, 16'h0, 6'd0, 7'd5}},
      '{REQ_REMOVE, 32'h1234_5678, 16'h0000, 1'b1, '{STAT_NOT_FOUND, 16'h0, 6'd0, 7'd5}},
      '{REQ_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, NO_WANT},
      '{REQ_REMOVE, 32'h8000_0000, 16'h0000, 1'b0, NO_WANT},
      '{REQ_LOOKUP, 32'h8000_0000, 16'h0000, 1'b0, NO_WANT},
      '{REQ_REMOVE, 32'h8000_0000, 16'h0000, 1'b0, NO_WANT},
      '{REQ_REMOVE, 32'hFFFF_FFFF, 16'h0000, 1'b0, NO_WANT},
      '{REQ_REMOVE, 32'h7FFF_FFFF, 16'h0000, 1'b0, NO_WANT},
      // Back to empty.
      '{REQ_LOOKUP, 32'h7FFF_FFFF, 16'h0000, 1'b1, '{STAT_NOT_FOUND, 16'h0, 6'd0, 7'd0}},
      '{REQ_INSERT, 32'hFFFF_FFFF, 16'h0001, 1'b1, '{STAT_OK, 16'h0, 6'd0, 7'd1}},
      '{REQ_REMOVE, 32'hFFFF_FFFF, 16'h0000, 1'b1, '{STAT_OK, 16'h0, 6'd0, 7'd0}}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      issue_request(directed_rows[i].req, directed_rows[i].key, directed_rows[i].pay,
                    directed_rows[i].fixed, directed_rows[i].want);
    wait_drained();

    // The full table is reached and emptied first, then episodes follow at
    // random until enough real requests have been sent.
    live_target = requests_live + RANDOM_ITEMS;
    run_episode(EP_FILL);
    run_episode(EP_DRAIN);
    while (requests_live < live_target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      mode = EP_FILL;
      else if (pick == 1) mode = EP_DRAIN;
      else if (pick < 5)  mode = EP_GROW;
      else if (pick < 7)  mode = EP_CHURN;
      else                mode = EP_MIXED;
      run_episode(mode);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results: %0d lookup hits, %0d misses,",
             requests_taken, results_seen, lookup_hits, misses);
    $display("%0d inserts, %0d removes, %0d refused on a full table, %0d unused codes, peak %0d.",
             inserts_done, removes_done, full_refusals, ignored_codes, peak_held);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Safety net: far beyond the slowest correct run.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("Timed out with %0d results still awaited.", awaited_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
